// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, muted while rst_n is low
`define SSSN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication shorthand for same-cycle checks
`define SSSN_ASSERT_IMP(label, ante, cons, msg) \
  `SSSN_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== hdl/sssn_pkg.sv =====
// shared types, constants and segment decode for the seven-segment scanner
// no dependencies
package sssn_pkg;

  localparam int DIGIT_COUNT_DEF = 8;
  localparam int VALUE_W         = 32;
  localparam int SEG_W           = 8;
  localparam int BCD_W           = 4;
  localparam int CNT_W           = $clog2(VALUE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LATCH
  } state_t;

  // control broadcast to every digit cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic latch;
  } cell_ctrl_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/sssn_cell.sv =====
// one display position: a bcd digit with shift-add-3 step and its segment store
// depends on sssn_pkg
module sssn_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sssn_pkg::cell_ctrl_t              ctrl,
  input  logic                              bit_in,
  output logic                              bit_out,
  input  logic                              lit_in,
  output logic                              lit_out,
  input  logic                              force_lit,
  output logic [sssn_pkg::SEG_W-1:0]        seg
);
  import sssn_pkg::*;

  logic [BCD_W-1:0] digit_r;
  logic [BCD_W-1:0] adj;
  logic [BCD_W-1:0] digit_nxt;
  logic [SEG_W-1:0] seg_r;
  logic [SEG_W-1:0] seg_nxt;

  // add 3 when the digit would overflow on doubling
  assign adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign digit_nxt = {adj[BCD_W-2:0], bit_in};
  assign bit_out   = adj[BCD_W-1];

  // lit once any digit at or left of here is nonzero
  assign lit_out = lit_in | (digit_r != '0);
  assign seg_nxt = (lit_out | force_lit) ? seg_code(digit_r) : '0;
  assign seg     = seg_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit_r <= '0;
    end else if (ctrl.shift) begin
      digit_r <= digit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= '0;
    end else if (ctrl.latch) begin
      seg_r <= seg_nxt;
    end
  end

endmodule

// ===== hdl/seven_segment_number_scanner_unit.sv =====
// top level of the multiplexed seven-segment display driver
// depends on sssn_pkg and sssn_cell
//
// Usage: drive in_func/in_value with start; a transfer happens at a clock edge
// where start is high and busy is low.
// Load (in_func = 1): in_value is converted to decimal in a row of digit cells
// by shift-add-3, one input bit per cycle. busy stays high through the 32
// conversion steps in the cell row and the state that latches segment
// codes, then the display store holds the low DIGIT_COUNT digits right
// aligned with leading positions blank. A load gives no result.
// Scan (in_func = 0): in the cycle after, out_valid pulses for one cycle with
// out_digit_select and out_segments of the current position, which then
// advances and wraps. Scans may be issued every cycle while busy is low.
// The receiver cannot stall: each result is there for exactly one cycle.
// Reset (rst_n low, synchronous) blanks the store, zeroes the scan position
// and returns to idle.
module seven_segment_number_scanner_unit #(
  parameter int DIGIT_COUNT = sssn_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [sssn_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [2:0]                    out_digit_select,
  output logic [sssn_pkg::SEG_W-1:0]    out_segments
);
  import sssn_pkg::*;

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  state_t             state_r;
  state_t             state_nxt;
  cell_ctrl_t         ctrl;
  logic [CNT_W-1:0]   cnt_r;
  logic [VALUE_W-1:0] value_r;
  logic               overflow_r;
  logic [POS_W-1:0]   scan_pos_r;
  logic [POS_W+2:0]   pos_ext;
  logic               out_valid_r;
  logic [2:0]         out_sel_r;
  logic [SEG_W-1:0]   out_seg_r;
  logic               accept;
  logic               load_go;
  logic               scan_go;

  logic               bit_w [DIGIT_COUNT];
  logic               lit_w [DIGIT_COUNT];
  logic [SEG_W-1:0]   seg_w [DIGIT_COUNT];

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start & ~busy;
  assign load_go = accept & in_func;
  assign scan_go = accept & ~in_func;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctrl.clear = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.latch = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctrl.clear = load_go;
        if (load_go) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.shift = 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = ST_LATCH;
        end
      end
      ST_LATCH: begin
        ctrl.latch = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // bit counter, input shift register and carry-out of the top digit
  always_ff @(posedge clk) begin
    if (load_go) begin
      cnt_r      <= '0;
      value_r    <= in_value;
      overflow_r <= 1'b0;
    end else if (ctrl.shift) begin
      cnt_r      <= cnt_r + 1'b1;
      value_r    <= {value_r[VALUE_W-2:0], 1'b0};
      overflow_r <= overflow_r | bit_w[0];
    end
  end

  // cell 0 is leftmost; bits enter at the right and carry leftward,
  // the lit flag runs rightward
  for (genvar p = 0; p < DIGIT_COUNT; p++) begin : g_cell
    logic b_in;
    logic l_in;
    if (p == DIGIT_COUNT - 1) begin : g_right
      assign b_in = value_r[VALUE_W-1];
    end else begin : g_mid
      assign b_in = bit_w[p+1];
    end
    if (p == 0) begin : g_left
      assign l_in = overflow_r;
    end else begin : g_inner
      assign l_in = lit_w[p-1];
    end
    sssn_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .bit_in    (b_in),
      .bit_out   (bit_w[p]),
      .lit_in    (l_in),
      .lit_out   (lit_w[p]),
      .force_lit (p == DIGIT_COUNT - 1),
      .seg       (seg_w[p])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= '0;
    end else if (scan_go) begin
      if (scan_pos_r == POS_W'(DIGIT_COUNT - 1)) begin
        scan_pos_r <= '0;
      end else begin
        scan_pos_r <= scan_pos_r + 1'b1;
      end
    end
  end

  assign pos_ext = {3'b000, scan_pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= scan_go;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go) begin
      out_sel_r <= pos_ext[2:0];
      out_seg_r <= seg_w[scan_pos_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = out_sel_r;
  assign out_segments     = out_seg_r;

endmodule

// ===== hdl/sssn_checker.sv =====
// port-level checks for the seven-segment scanner, bound to the top level
// depends on sssn_pkg and assert_macros.svh
`include "assert_macros.svh"

module sssn_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_func,
  input  logic                          out_valid
);
  import sssn_pkg::*;

  // span of a load: conversion steps, then the latch state, then idle
  localparam int LOAD_SPAN = VALUE_W + 2;

  logic scan_xfer;
  logic load_xfer;

  assign scan_xfer = start & ~busy & ~in_func;
  assign load_xfer = start & ~busy & in_func;

  `SSSN_ASSERT(a_scan_gives_result, scan_xfer |=> out_valid, "scan transfer without result")
  `SSSN_ASSERT(a_no_spurious_result, !scan_xfer |=> !out_valid, "result without scan transfer")
  `SSSN_ASSERT(a_load_sets_busy, load_xfer |=> busy, "load did not raise busy")
  `SSSN_ASSERT(a_load_ends, load_xfer |-> ##LOAD_SPAN !busy, "load conversion did not finish")
  `SSSN_ASSERT_IMP(a_no_result_while_busy, busy && $past(busy), !out_valid, "result in conversion")

endmodule

bind seven_segment_number_scanner_unit sssn_checker u_sssn_checker (.*);
